// ===== hw/rtl/t10pek_pkg.sv =====
// Shared types, constants and helper functions for the tet10 projection element kernel.
// Used by t10pek_ctrl, t10pek_datapath and tet10_projection_element_kernel; depends on nothing.
package t10pek_pkg;

   localparam int NUM_CORNERS = 4;
   localparam int NUM_SLOTS   = 10;

   localparam logic [1:0] TRIGGER_CORNER  = 2'd3;
   localparam logic [3:0] FIRST_EDGE_SLOT = 4'd4;
   localparam logic [3:0] LAST_SLOT       = 4'd9;
   localparam logic [1:0] TOP_CHUNK       = 2'd2;

   // floor(v / 75) = (v * RECIP_75) >> 34, exact for v < 2**27
   localparam logic [27:0] RECIP_75       = 28'd229064923;
   // floor(v / 75) = (v * RECIP_75_SMALL) >> 19, exact for v < 5625
   localparam logic [12:0] RECIP_75_SMALL = 13'd6991;

   // Half of 600 * 2**32 and of 600 * 2**16, already divided by 75
   localparam logic [72:0] PROJ_ROUND = 73'd1 << 34;
   localparam logic [49:0] MASS_ROUND = 50'd1 << 18;

   typedef struct packed {
      logic [1:0]         corner;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
      logic signed [23:0] corner_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         slot;
      logic signed [47:0] projected;
      logic signed [47:0] mass_weight;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MINOR,
      ST_DET_MUL,
      ST_DET_SUM,
      ST_MV_MUL,
      ST_MV_FIX,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic       load_corner;
      logic       calc_diff;
      logic       calc_minor;
      logic       det_mul;
      logic       det_sum;
      logic       mv_mul;
      logic       mv_fix;
      logic [1:0] mv_chunk;
      logic       issue;
      logic [3:0] issue_slot;
   } cmd_type;

   typedef struct packed {
      logic advance;
      logic pipe_busy;
   } stat_type;

   // Corner weight of a slot as a left shift: 0 for 1, 1 for 2, 2 for 4
   function automatic logic [1:0] weight_shift(input logic [3:0] slot, input logic [1:0] idx);
      logic [7:0] row;
      case (slot)
         4'd0:    row = 8'b00_00_00_10;
         4'd1:    row = 8'b00_00_10_00;
         4'd2:    row = 8'b00_10_00_00;
         4'd3:    row = 8'b10_00_00_00;
         4'd4:    row = 8'b01_01_10_10;
         4'd5:    row = 8'b01_10_10_01;
         4'd6:    row = 8'b01_10_01_10;
         4'd7:    row = 8'b10_01_01_10;
         4'd8:    row = 8'b10_01_10_01;
         4'd9:    row = 8'b10_10_01_01;
         default: row = 8'b00_00_00_00;
      endcase
      return row[{idx, 1'b0} +: 2];
   endfunction

   // Remainder of v after taking out q times 75
   function automatic logic [6:0] div75_rem(input logic [26:0] v, input logic [20:0] q);
      logic [26:0] q75;
      logic [26:0] r;
      q75 = (27'(q) << 6) + (27'(q) << 3) + (27'(q) << 1) + 27'(q);
      r   = v - q75;
      return r[6:0];
   endfunction

endpackage

// ===== hw/rtl/t10pek_ctrl.sv =====
// Sequencer for the tet10 projection element kernel: input handshake, determinant
// steps, divide-by-75 steps, slot issue and drain. Depends on t10pek_pkg.
module t10pek_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_corner,
   output logic                 req_ready,
   input  t10pek_pkg::stat_type stat,
   output t10pek_pkg::cmd_type  cmd
);

   t10pek_pkg::state_type state_ff, state_in;
   logic [3:0] slot_ff, slot_in;
   logic [1:0] chunk_ff, chunk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= t10pek_pkg::ST_IDLE;
         slot_ff  <= '0;
         chunk_ff <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
         chunk_ff <= chunk_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      slot_in        = slot_ff;
      chunk_in       = chunk_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.mv_chunk   = chunk_ff;
      cmd.issue_slot = slot_ff;
      case (state_ff)
         t10pek_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.load_corner = req_valid;
            if (req_valid && req_corner == t10pek_pkg::TRIGGER_CORNER) begin
               state_in = t10pek_pkg::ST_DIFF;
            end
         end
         t10pek_pkg::ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = t10pek_pkg::ST_MINOR;
         end
         t10pek_pkg::ST_MINOR: begin
            cmd.calc_minor = 1'b1;
            state_in       = t10pek_pkg::ST_DET_MUL;
         end
         t10pek_pkg::ST_DET_MUL: begin
            cmd.det_mul = 1'b1;
            state_in    = t10pek_pkg::ST_DET_SUM;
         end
         t10pek_pkg::ST_DET_SUM: begin
            cmd.det_sum = 1'b1;
            chunk_in    = t10pek_pkg::TOP_CHUNK;
            state_in    = t10pek_pkg::ST_MV_MUL;
         end
         t10pek_pkg::ST_MV_MUL: begin
            cmd.mv_mul = 1'b1;
            state_in   = t10pek_pkg::ST_MV_FIX;
         end
         t10pek_pkg::ST_MV_FIX: begin
            cmd.mv_fix = 1'b1;
            if (chunk_ff == 2'd0) begin
               slot_in  = '0;
               state_in = t10pek_pkg::ST_ISSUE;
            end else begin
               chunk_in = chunk_ff - 2'd1;
               state_in = t10pek_pkg::ST_MV_MUL;
            end
         end
         t10pek_pkg::ST_ISSUE: begin
            // issue one slot per pipeline advance
            cmd.issue = stat.advance;
            if (stat.advance) begin
               if (slot_ff == t10pek_pkg::LAST_SLOT) begin
                  state_in = t10pek_pkg::ST_DRAIN;
               end else begin
                  slot_in = slot_ff + 4'd1;
               end
            end
         end
         t10pek_pkg::ST_DRAIN: begin
            // the output register may still hold a beat; only the inner stages must empty
            if (!stat.pipe_busy) begin
               state_in = t10pek_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = t10pek_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/t10pek_datapath.sv =====
// Datapath of the tet10 projection element kernel: corner store, determinant,
// divide-by-75 steps and the six-stage slot pipeline ending in the output register.
// Depends on t10pek_pkg.
module t10pek_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  t10pek_pkg::req_type  req_data,
   input  t10pek_pkg::cmd_type  cmd,
   output t10pek_pkg::stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output t10pek_pkg::rsp_type  rsp_data
);

   typedef struct packed {
      logic [3:0]  slot;
      logic        neg;
      logic [26:0] ms;
   } s1_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic        neg;
      logic [26:0] ms;
      logic [20:0] q;
      logic [49:0] pl;
      logic [48:0] ph;
   } s2_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic        neg;
      logic [20:0] qs;
      logic [6:0]  rs;
      logic [71:0] qm;
   } s3_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic        neg;
      logic [71:0] qm;
      logic [27:0] t1;
      logic [13:0] x;
      logic [48:0] cq;
      logic [9:0]  x2;
   } s4_type;

   typedef struct packed {
      logic [3:0]  slot;
      logic        neg;
      logic [72:0] sum;
      logic [6:0]  y;
      logic [49:0] m1;
      logic [6:0]  y2;
   } s5_type;

   // corner store
   logic signed [15:0] cx_ff [t10pek_pkg::NUM_CORNERS];
   logic signed [15:0] cy_ff [t10pek_pkg::NUM_CORNERS];
   logic signed [15:0] cz_ff [t10pek_pkg::NUM_CORNERS];
   logic signed [23:0] cv_ff [t10pek_pkg::NUM_CORNERS];

   // determinant
   logic signed [16:0] dx_ff [3], dx_in [3];
   logic signed [16:0] dy_ff [3], dy_in [3];
   logic signed [16:0] dz_ff [3], dz_in [3];
   logic signed [34:0] minor_ff [3], minor_in [3];
   logic signed [51:0] term_ff [3], term_in [3];
   logic signed [53:0] vol;
   logic [53:0]        vol_mag;
   logic [50:0]        mv_ff, mv_in;
   logic               vneg_ff, vneg_in;

   // divide |V| by 75, one 17-bit chunk per two steps
   logic [16:0] chunk;
   logic [26:0] div_val;
   logic [54:0] div_prod;
   logic [16:0] mv_q_ff, mv_q_in;
   logic [23:0] mv_val_ff, mv_val_in;
   logic [6:0]  mv_rem_ff, mv_rem_in;
   logic [44:0] qv_ff, qv_in;

   // slot pipeline
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   s1_type             s1_ff, s1_in;
   s2_type             s2_ff, s2_in;
   s3_type             s3_ff, s3_in;
   s4_type             s4_ff, s4_in;
   s5_type             s5_ff, s5_in;
   logic signed [27:0] sum_acc;
   logic signed [27:0] sum_mag;
   logic [1:0]         sh;
   logic               is_edge;
   logic [26:0]        yprod, y2prod;
   logic [72:0]        zp;
   logic [49:0]        zm;
   logic [37:0]        pmag;
   logic [30:0]        mmag;
   logic               rsp_valid_ff;
   t10pek_pkg::rsp_type rsp_ff, rsp_in;
   logic               advance;

   assign advance        = !rsp_valid_ff || rsp_ready;
   assign stat.advance   = advance;
   assign stat.pipe_busy = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff | s5_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < t10pek_pkg::NUM_CORNERS; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
            cz_ff[i] <= '0;
            cv_ff[i] <= '0;
         end
      end else if (cmd.load_corner) begin
         cx_ff[req_data.corner] <= req_data.coord_x;
         cy_ff[req_data.corner] <= req_data.coord_y;
         cz_ff[req_data.corner] <= req_data.coord_z;
         cv_ff[req_data.corner] <= req_data.corner_value;
      end
   end

   // corner differences d_k = p0 - p(k+1), minors, products, then V = -det
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dx_in[k] = 17'(cx_ff[0]) - 17'(cx_ff[k + 1]);
         dy_in[k] = 17'(cy_ff[0]) - 17'(cy_ff[k + 1]);
         dz_in[k] = 17'(cz_ff[0]) - 17'(cz_ff[k + 1]);
      end
      minor_in[0] = 35'(dy_ff[1]) * 35'(dz_ff[2]) - 35'(dz_ff[1]) * 35'(dy_ff[2]);
      minor_in[1] = 35'(dx_ff[1]) * 35'(dz_ff[2]) - 35'(dz_ff[1]) * 35'(dx_ff[2]);
      minor_in[2] = 35'(dx_ff[1]) * 35'(dy_ff[2]) - 35'(dy_ff[1]) * 35'(dx_ff[2]);
      term_in[0]  = 52'(dx_ff[0]) * 52'(minor_ff[0]);
      term_in[1]  = 52'(dy_ff[0]) * 52'(minor_ff[1]);
      term_in[2]  = 52'(dz_ff[0]) * 52'(minor_ff[2]);
      vol         = 54'(term_ff[1]) - 54'(term_ff[0]) - 54'(term_ff[2]);
      vol_mag     = vol[53] ? 54'(-vol) : 54'(vol);
      mv_in       = vol_mag[50:0];
      vneg_in     = vol[53];
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_diff) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dz_ff <= dz_in;
      end
      if (cmd.calc_minor) begin
         minor_ff <= minor_in;
      end
      if (cmd.det_mul) begin
         term_ff <= term_in;
      end
      if (cmd.det_sum) begin
         mv_ff   <= mv_in;
         vneg_ff <= vneg_in;
      end
   end

   // shared reciprocal multiplier: |V| chunks during setup, slot sums in the pipeline
   always_comb begin
      case (cmd.mv_chunk)
         2'd2:    chunk = mv_ff[50:34];
         2'd1:    chunk = mv_ff[33:17];
         default: chunk = mv_ff[16:0];
      endcase
      div_val   = cmd.mv_mul ? {3'b000, mv_rem_ff, chunk} : s1_ff.ms;
      div_prod  = 55'(div_val) * 55'(t10pek_pkg::RECIP_75);
      mv_q_in   = div_prod[50:34];
      mv_val_in = div_val[23:0];
      mv_rem_in = t10pek_pkg::div75_rem(27'(mv_val_ff), 21'(mv_q_ff));
      qv_in     = {qv_ff[27:0], mv_q_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.det_sum) begin
         mv_rem_ff <= '0;
      end else if (cmd.mv_fix) begin
         mv_rem_ff <= mv_rem_in;
         qv_ff     <= qv_in;
      end
      if (cmd.mv_mul) begin
         mv_q_ff   <= mv_q_in;
         mv_val_ff <= mv_val_in;
      end
   end

   // stage 1: weighted corner sum and its magnitude
   always_comb begin
      sum_acc = '0;
      sh      = '0;
      for (int i = 0; i < t10pek_pkg::NUM_CORNERS; i++) begin
         sh      = t10pek_pkg::weight_shift(cmd.issue_slot, 2'(i));
         sum_acc = sum_acc + (28'(cv_ff[i]) <<< sh);
      end
      sum_mag    = sum_acc[27] ? -sum_acc : sum_acc;
      s1_in.slot = cmd.issue_slot;
      s1_in.neg  = sum_acc[27];
      s1_in.ms   = sum_mag[26:0];
   end

   // stages 2..5: split |V| / 75 = Qv rem Rv and |S| / 75 = Qs rem Rs
   always_comb begin
      s2_in.slot = s1_ff.slot;
      s2_in.neg  = s1_ff.neg;
      s2_in.ms   = s1_ff.ms;
      s2_in.q    = div_prod[54:34];
      s2_in.pl   = 50'(qv_ff[22:0]) * 50'(s1_ff.ms);
      s2_in.ph   = 49'(qv_ff[44:23]) * 49'(s1_ff.ms);

      s3_in.slot = s2_ff.slot;
      s3_in.neg  = s2_ff.neg;
      s3_in.qs   = s2_ff.q;
      s3_in.rs   = t10pek_pkg::div75_rem(s2_ff.ms, s2_ff.q);
      s3_in.qm   = (72'(s2_ff.ph) << 23) + 72'(s2_ff.pl);

      is_edge    = s3_ff.slot >= t10pek_pkg::FIRST_EDGE_SLOT;
      s4_in.slot = s3_ff.slot;
      s4_in.neg  = s3_ff.neg;
      s4_in.qm   = s3_ff.qm;
      s4_in.t1   = 28'(mv_rem_ff) * 28'(s3_ff.qs);
      s4_in.x    = 14'(mv_rem_ff) * 14'(s3_ff.rs);
      // mass factor: 7 on corners, 12 on edges
      s4_in.cq   = is_edge ? (49'(qv_ff) << 3) + (49'(qv_ff) << 2)
                           : (49'(qv_ff) << 3) - 49'(qv_ff);
      s4_in.x2   = is_edge ? (10'(mv_rem_ff) << 3) + (10'(mv_rem_ff) << 2)
                           : (10'(mv_rem_ff) << 3) - 10'(mv_rem_ff);

      yprod      = 27'(s4_ff.x) * 27'(t10pek_pkg::RECIP_75_SMALL);
      y2prod     = 27'(s4_ff.x2) * 27'(t10pek_pkg::RECIP_75_SMALL);
      s5_in.slot = s4_ff.slot;
      s5_in.neg  = s4_ff.neg;
      s5_in.sum  = 73'(s4_ff.qm) + 73'(s4_ff.t1) + t10pek_pkg::PROJ_ROUND;
      s5_in.y    = yprod[25:19];
      s5_in.m1   = 50'(s4_ff.cq) + t10pek_pkg::MASS_ROUND;
      s5_in.y2   = y2prod[25:19];
   end

   // output stage: divide by 2**35 and 2**19, apply signs
   always_comb begin
      zp                 = s5_ff.sum + 73'(s5_ff.y);
      zm                 = s5_ff.m1 + 50'(s5_ff.y2);
      pmag               = zp[72:35];
      mmag               = zm[49:19];
      rsp_in.slot        = s5_ff.slot;
      rsp_in.projected   = (s5_ff.neg ^ vneg_ff) ? -48'(pmag) : 48'(pmag);
      rsp_in.mass_weight = vneg_ff ? -48'(mmag) : 48'(mmag);
      rsp_in.last        = s5_ff.slot == t10pek_pkg::LAST_SLOT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cmd.issue;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   // hold every stage while the output beat waits
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== hw/rtl/tet10_projection_element_kernel.sv =====
// Top level of the tet10 projection element kernel: controller plus datapath.
// Depends on t10pek_pkg, t10pek_ctrl and t10pek_datapath.
//
//   channel   ports                          beat
//   req       req_valid req_ready req_data   one tetrahedron corner (t10pek_pkg::req_type)
//   rsp       rsp_valid rsp_ready rsp_data   one element slot result (t10pek_pkg::rsp_type)
//
// Corners 0..2 are taken while the controller is idle. Corner 3 holds req_ready low through
// the determinant steps, the divide-by-75 steps on |V| through the shared 27x28 reciprocal
// multiplier, 10 slot issues into the six-stage slot pipeline and the drain of its inner
// stages.
// Reset clears the corner store to zero and empties the pipeline.
// rsp_ready low freezes the slot pipeline; the last result may wait while new corners load.
module tet10_projection_element_kernel (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  t10pek_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output t10pek_pkg::rsp_type rsp_data
);

   t10pek_pkg::cmd_type  cmd;
   t10pek_pkg::stat_type stat;

   t10pek_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_corner (req_data.corner),
      .req_ready  (req_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   t10pek_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/tet10_projection_element_kernel_test.sv =====
// Self-checking bench for tet10_projection_element_kernel: corner beats in, slot beats out.
// Depends on t10pek_pkg and the kernel RTL; predicts each element's ten slots in-line.
module tet10_projection_element_kernel_test;

   localparam int QUIET_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 60;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_REPORTS   = 10;

   localparam logic signed [15:0] COORD_MAX = 16'sh7FFF;
   localparam logic signed [15:0] COORD_MIN = 16'sh8000;
   localparam logic signed [23:0] VALUE_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] VALUE_MIN = 24'sh800000;

   localparam logic [1:0] CORNER_0 = 2'd0;
   localparam logic [1:0] CORNER_1 = 2'd1;
   localparam logic [1:0] CORNER_2 = 2'd2;

   localparam int MASS_CORNER = 7;
   localparam int MASS_EDGE   = 12;

   localparam logic [127:0] PROJ_DIV    = 128'd600 << 32;
   localparam logic [127:0] MASS_DIV    = 128'd600 << 16;
   localparam logic [127:0] SAT_POS_MAG = 128'h7FFF_FFFF_FFFF;
   localparam logic [127:0] SAT_NEG_MAG = 128'h8000_0000_0000;

   // corner weights per slot, edge rows already doubled for the 1/300 scale
   localparam int CORNER_WEIGHT [t10pek_pkg::NUM_SLOTS][t10pek_pkg::NUM_CORNERS] = '{
      '{4, 1, 1, 1}, '{1, 4, 1, 1}, '{1, 1, 4, 1}, '{1, 1, 1, 4},
      '{4, 4, 2, 2}, '{2, 4, 4, 2}, '{4, 2, 4, 2}, '{4, 2, 2, 4},
      '{2, 4, 2, 4}, '{2, 2, 4, 4}};

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   t10pek_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   t10pek_pkg::rsp_type rsp_data;

   t10pek_pkg::req_type corner_feed [$];
   t10pek_pkg::rsp_type expected_slots [$];

   logic signed [15:0] held_coord [t10pek_pkg::NUM_CORNERS][3];
   logic signed [23:0] held_value [t10pek_pkg::NUM_CORNERS];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int recv_hold_left = 0;
   int quiet_cycles   = 0;
   int mismatches     = 0;
   int corners_taken  = 0;
   int elements_taken = 0;
   int slots_checked  = 0;

   tet10_projection_element_kernel dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // magnitude divide with rounding half away from zero, then 48-bit saturation
   function automatic logic [47:0] scaled_round(input logic [127:0] num,
                                                input logic [127:0] den, input bit neg);
      logic [127:0] q;
      logic [127:0] rem;
      q   = num / den;
      rem = num - q * den;
      if ((rem << 1) >= den) q = q + 1;
      if (neg) begin
         if (q > SAT_NEG_MAG) q = SAT_NEG_MAG;
         q = -q;
      end else if (q > SAT_POS_MAG) begin
         q = SAT_POS_MAG;
      end
      return q[47:0];
   endfunction

   // store the corner; corner 3 fires the element and queues its ten slots
   function automatic void absorb_corner(input t10pek_pkg::req_type beat);
      longint              d [3][3];
      longint              vol;
      longint              wsum;
      logic [127:0]        vmag;
      logic [127:0]        smag;
      bit                  vneg;
      bit                  sneg;
      t10pek_pkg::rsp_type slot_out;
      held_coord[beat.corner][0] = beat.coord_x;
      held_coord[beat.corner][1] = beat.coord_y;
      held_coord[beat.corner][2] = beat.coord_z;
      held_value[beat.corner]    = beat.corner_value;
      if (beat.corner != t10pek_pkg::TRIGGER_CORNER) return;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            d[k][i] = longint'(held_coord[0][i]) - longint'(held_coord[k + 1][i]);
      vol = d[0][0] * d[1][1] * d[2][2] - d[0][0] * d[2][1] * d[1][2]
          - d[1][1] * d[0][2] * d[2][0] - d[2][2] * d[1][0] * d[0][1]
          + d[1][0] * d[2][1] * d[0][2] + d[2][0] * d[0][1] * d[1][2];
      vol  = -vol;
      vneg = vol < 0;
      vmag = 128'(vneg ? -vol : vol);
      for (int k = 0; k < t10pek_pkg::NUM_SLOTS; k++) begin
         wsum = 0;
         for (int i = 0; i < t10pek_pkg::NUM_CORNERS; i++)
            wsum += CORNER_WEIGHT[k][i] * longint'(held_value[i]);
         sneg = wsum < 0;
         smag = 128'(sneg ? -wsum : wsum);
         slot_out.slot        = 4'(k);
         slot_out.projected   = scaled_round(vmag * smag, PROJ_DIV, vneg != sneg);
         slot_out.mass_weight = scaled_round(vmag * ((4'(k) < t10pek_pkg::FIRST_EDGE_SLOT) ?
                                   MASS_CORNER : MASS_EDGE), MASS_DIV, vneg);
         slot_out.last        = (4'(k) == t10pek_pkg::LAST_SLOT);
         expected_slots.push_back(slot_out);
      end
   endfunction

   function automatic t10pek_pkg::req_type corner_at(input logic [1:0] c,
                                                     input logic signed [15:0] x,
                                                     input logic signed [15:0] y,
                                                     input logic signed [15:0] z,
                                                     input logic signed [23:0] value);
      t10pek_pkg::req_type beat;
      beat.corner       = c;
      beat.coord_x      = x;
      beat.coord_y      = y;
      beat.coord_z      = z;
      beat.corner_value = value;
      return beat;
   endfunction

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(7))
         0:       return COORD_MAX;
         1:       return COORD_MIN;
         2:       return 16'(int'($urandom_range(255)) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic signed [23:0] pick_value();
      case ($urandom_range(7))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic t10pek_pkg::req_type random_corner(input logic [1:0] c);
      return corner_at(c, pick_coord(), pick_coord(), pick_coord(), pick_value());
   endfunction

   // driver: hold a beat until taken, then maybe offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_corner(req_data);
            corners_taken++;
            if (req_data.corner == t10pek_pkg::TRIGGER_CORNER) elements_taken++;
         end
         if (!req_valid || req_ready) begin
            if (corner_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= corner_feed.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each slot beat against the oldest prediction
   always @(posedge clock) begin
      t10pek_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_slots.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected slot beat: slot %0d projected %0d mass %0d last %0b",
                           rsp_data.slot, rsp_data.projected, rsp_data.mass_weight,
                           rsp_data.last);
            end else begin
               want = expected_slots.pop_front();
               slots_checked++;
               if (rsp_data.slot !== want.slot || rsp_data.projected !== want.projected ||
                   rsp_data.mass_weight !== want.mass_weight || rsp_data.last !== want.last)
               begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("slot mismatch: exp slot %0d projected %0d mass %0d last %0b",
                              want.slot, want.projected, want.mass_weight, want.last);
                     $display("               got slot %0d projected %0d mass %0d last %0b",
                              rsp_data.slot, rsp_data.projected, rsp_data.mass_weight,
                              rsp_data.last);
                  end
               end
            end
         end
         if (recv_hold_left > 0) begin
            rsp_ready      <= 1'b0;
            recv_hold_left <= recv_hold_left - 1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tet10_projection_element_kernel_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_random_corners(input int count);
      int added;
      int len;
      added = 0;
      while (added < count) begin
         if ($urandom_range(9) < 8) begin
            for (int c = 0; c < t10pek_pkg::NUM_CORNERS; c++)
               corner_feed.push_back(random_corner(2'(c)));
            added += t10pek_pkg::NUM_CORNERS;
         end else begin
            // broken sequence: random corners, skips and repeats
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
               corner_feed.push_back(random_corner(2'($urandom_range(3))));
            added += len;
         end
      end
   endtask

   // drain the feed, then wait until every predicted slot has come back
   task automatic drain_all();
      while (corner_feed.size() != 0 || req_valid) @(negedge clock);
      while (expected_slots.size() != 0) @(negedge clock);
   endtask

   task automatic random_phase(input int send_pct, input int recv_pct, input int count);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      queue_random_corners(count);
      drain_all();
   endtask

   initial begin
      for (int i = 0; i < t10pek_pkg::NUM_CORNERS; i++) begin
         held_value[i] = '0;
         for (int j = 0; j < 3; j++) held_coord[i][j] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // lone corner 3 after reset: the other corners are zero, so the volume is zero
      corner_feed.push_back(corner_at(t10pek_pkg::TRIGGER_CORNER, COORD_MAX, COORD_MIN,
                                      COORD_MAX, VALUE_MAX));
      // largest volume, extreme values of both signs and orientations
      corner_feed.push_back(corner_at(CORNER_0, COORD_MIN, COORD_MIN, COORD_MIN, VALUE_MAX));
      corner_feed.push_back(corner_at(CORNER_1, COORD_MAX, COORD_MIN, COORD_MIN, VALUE_MAX));
      corner_feed.push_back(corner_at(CORNER_2, COORD_MIN, COORD_MAX, COORD_MIN, VALUE_MAX));
      corner_feed.push_back(corner_at(t10pek_pkg::TRIGGER_CORNER, COORD_MIN, COORD_MIN,
                                      COORD_MAX, VALUE_MAX));
      corner_feed.push_back(corner_at(CORNER_0, COORD_MIN, COORD_MIN, COORD_MIN, VALUE_MIN));
      corner_feed.push_back(corner_at(CORNER_1, COORD_MIN, COORD_MAX, COORD_MIN, VALUE_MIN));
      corner_feed.push_back(corner_at(CORNER_2, COORD_MAX, COORD_MIN, COORD_MIN, VALUE_MIN));
      corner_feed.push_back(corner_at(t10pek_pkg::TRIGGER_CORNER, COORD_MIN, COORD_MIN,
                                      COORD_MAX, VALUE_MIN));
      // repeated corner, then trigger reusing the rest of the previous element
      corner_feed.push_back(corner_at(CORNER_1, 16'sh1000, 16'sh0000, 16'sh0000, 24'sh010000));
      corner_feed.push_back(corner_at(CORNER_1, 16'sh2000, 16'sh0100, 16'shF000, 24'shFF0000));
      corner_feed.push_back(corner_at(t10pek_pkg::TRIGGER_CORNER, 16'sh0000, 16'sh0000,
                                      16'sh1000, 24'sh000001));
      // unit-ish element with mixed-sign values
      corner_feed.push_back(corner_at(CORNER_0, 16'sh0000, 16'sh0000, 16'sh0000, VALUE_MAX));
      corner_feed.push_back(corner_at(CORNER_1, 16'sh1000, 16'sh0000, 16'sh0000, VALUE_MIN));
      corner_feed.push_back(corner_at(CORNER_2, 16'sh0000, 16'sh1000, 16'sh0000, 24'sh000000));
      corner_feed.push_back(corner_at(t10pek_pkg::TRIGGER_CORNER, 16'sh0000, 16'sh0000,
                                      16'sh1000, 24'shFFFFFF));
      // flat element: all corners in one plane
      corner_feed.push_back(corner_at(CORNER_0, 16'sh0123, 16'sh0456, 16'sh0800, 24'sh123456));
      corner_feed.push_back(corner_at(CORNER_1, 16'sh7000, 16'sh9000, 16'sh0800, 24'sh654321));
      corner_feed.push_back(corner_at(CORNER_2, 16'shA000, 16'sh5000, 16'sh0800, 24'shABCDEF));
      corner_feed.push_back(corner_at(t10pek_pkg::TRIGGER_CORNER, 16'sh3333, 16'shCCCC,
                                      16'sh0800, 24'sh7654FE));
      drain_all();

      // long receiver hold-off while corners keep coming, so the kernel backs up
      recv_hold_left = LONG_HOLD;
      random_phase(0, 0, 62);
      random_phase(81, 0, 62);
      random_phase(0, 81, 62);
      random_phase(8, 8, 62);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d corner beats, %0d elements, %0d slot beats checked",
               corners_taken, elements_taken, slots_checked);
      $display("phases: back-to-back with a %0d-cycle output hold, sender idle, receiver stall,"
               , LONG_HOLD, " light mixed idling");
      if (mismatches == 0 && expected_slots.size() == 0) begin
         $display("tet10_projection_element_kernel_test: done, clean");
      end else begin
         $display("tet10_projection_element_kernel_test: done, errors");
      end
      $finish;
   end

endmodule
